/* design/color_key_span_blitter_assert.svh */
// ----------------------------------------------------------------------------
// color key span blitter assertion macros
// shared same-cycle-implication and next-cycle property forms
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_SPAN_BLITTER_ASSERT_SVH
`define COLOR_KEY_SPAN_BLITTER_ASSERT_SVH

// same-cycle implication
`define CKB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CKB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ckb_pkg.sv */
// ----------------------------------------------------------------------------
// ckb_pkg
// constants, register indexes and color packing for the span blitter
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

	localparam int MAX_ROW_WIDTH = 32;
	localparam int IDX_W         = $clog2(MAX_ROW_WIDTH);
	localparam int CNT_W         = $clog2(MAX_ROW_WIDTH + 1);
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE   = 3'd6;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	typedef logic [15:0] rgb565_t;

	function automatic rgb565_t rgb565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

`default_nettype wire

/* design/color_key_span_blitter.sv */
// a closing pixel's header passes the header state, then the output register
// a pixel that does not close a span leaves the block idle, ready for another pixel
// a closing pixel stalls input until header and n pixels are out, one buffer read each
// reset: arst_n clears config to defaults, span state, sequencer and output valid
// ----------------------------------------------------------------------------
// color_key_span_blitter
// black-keyed spans, clipped if enabled, buffered in a 32-entry memory and emitted
// as a window header followed by RGB565 pixels
// ----------------------------------------------------------------------------
`default_nettype none

module color_key_span_blitter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [ckb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ckb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [15:0]                   origin_x,
	input  wire logic signed [15:0]                   origin_y,
	input  wire logic [4:0]                           column,
	input  wire logic [7:0]                           row_index,
	input  wire logic [7:0]                           red,
	input  wire logic [7:0]                           green,
	input  wire logic [7:0]                           blue,
	input  wire logic                                 end_of_row,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      kind,
	output logic signed [15:0]                        window_x,
	output logic signed [15:0]                        window_y,
	output logic [5:0]                                span_len,
	output logic [15:0]                               color,
	output logic                                      last
);

	import ckb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HDR  = 2'd1;
	localparam logic [1:0] S_PIX  = 2'd2;

	logic [1:0]          state_q;

	logic signed [15:0]  clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [12:0]         screen_width_q, screen_height_q;
	logic                clip_enable_q;

	logic                span_open_q;
	logic [IDX_W-1:0]    span_first_q;
	logic [CNT_W-1:0]    span_count_q;

	logic signed [15:0]  hdr_x_q, hdr_y_q;
	logic [CNT_W-1:0]    hdr_cnt_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_valid_s1;
	rgb565_t             rd_data_s1;

	rgb565_t             span_mem [MAX_ROW_WIDTH];

	logic                out_valid_q, kind_q, last_q;
	logic signed [15:0]  window_x_q, window_y_q;
	logic [5:0]          span_len_q;
	logic [15:0]         color_q;

	logic                accept, out_free, consume, fetch;
	logic signed [16:0]  sx, sy;
	logic                keyed, clipped, visible, open_eff, append, close;
	logic [IDX_W-1:0]    first_eff;
	logic [CNT_W-1:0]    cnt_base, cnt_new;
	rgb565_t             pix_color;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign consume  = (state_q == S_PIX) && rd_valid_s1 && out_free;
	assign fetch    = (state_q == S_PIX) && (!rd_valid_s1 || consume) &&
		(rd_idx_q != hdr_cnt_q);

	always_comb begin
		sx = {origin_x[15], origin_x} + 17'(column);
		sy = {origin_y[15], origin_y} + 17'(row_index);
		keyed = (red | green | blue) != 8'd0;
		clipped = (sx < $signed({clip_left_q[15], clip_left_q})) ||
			(sx >= $signed({clip_right_q[15], clip_right_q})) ||
			(sy < $signed({clip_top_q[15], clip_top_q})) ||
			(sy >= $signed({clip_bottom_q[15], clip_bottom_q})) ||
			(sx < 17'sd0) || (sx >= $signed({4'd0, screen_width_q})) ||
			(sy < 17'sd0) || (sy >= $signed({4'd0, screen_height_q}));
		visible   = keyed && !(clip_enable_q && clipped);
		open_eff  = span_open_q || visible;
		first_eff = span_open_q ? span_first_q : column;
		cnt_base  = span_open_q ? span_count_q : '0;
		append    = visible && (cnt_base < CNT_W'(MAX_ROW_WIDTH));
		cnt_new   = append ? cnt_base + CNT_W'(1) : cnt_base;
		close     = (!visible || end_of_row) && open_eff;
		pix_color = rgb565(red, green, blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q     <= 16'sd0;
			clip_top_q      <= 16'sd0;
			clip_right_q    <= 16'sd240;
			clip_bottom_q   <= 16'sd320;
			screen_width_q  <= 13'd240;
			screen_height_q <= 13'd320;
			clip_enable_q   <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CLIP_LEFT:     clip_left_q     <= cfg_data;
				REG_CLIP_TOP:      clip_top_q      <= cfg_data;
				REG_CLIP_RIGHT:    clip_right_q    <= cfg_data;
				REG_CLIP_BOTTOM:   clip_bottom_q   <= cfg_data;
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				REG_CLIP_ENABLE:   clip_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// span buffer
	always_ff @(posedge clk) begin
		if (accept && append) begin
			span_mem[cnt_base[IDX_W-1:0]] <= pix_color;
		end
		if (fetch) begin
			rd_data_s1 <= span_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && close) begin
			hdr_x_q   <= origin_x + 16'(first_eff);
			hdr_y_q   <= origin_y + 16'(row_index);
			hdr_cnt_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			span_open_q  <= 1'b0;
			span_first_q <= '0;
			span_count_q <= '0;
			rd_idx_q     <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (close) begin
							span_open_q  <= 1'b0;
							span_first_q <= '0;
							span_count_q <= '0;
							state_q      <= S_HDR;
						end else begin
							span_open_q  <= open_eff;
							span_first_q <= first_eff;
							span_count_q <= cnt_new;
						end
					end
				end
				S_HDR: begin
					if (out_free) begin
						rd_idx_q    <= '0;
						rd_valid_s1 <= 1'b0;
						state_q     <= (hdr_cnt_q == '0) ? S_IDLE : S_PIX;
					end
				end
				S_PIX: begin
					if (fetch) begin
						rd_idx_q    <= rd_idx_q + CNT_W'(1);
						rd_valid_s1 <= 1'b1;
					end else if (consume) begin
						rd_valid_s1 <= 1'b0;
						if (rd_idx_q == hdr_cnt_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_HDR && out_free) || consume) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HDR && out_free) begin
			kind_q       <= KIND_HEADER;
			window_x_q   <= hdr_x_q;
			window_y_q   <= hdr_y_q;
			span_len_q   <= 6'(hdr_cnt_q);
			color_q      <= '0;
			last_q       <= (hdr_cnt_q == '0);
		end else if (consume) begin
			kind_q       <= KIND_PIXEL;
			window_x_q   <= '0;
			window_y_q   <= '0;
			span_len_q   <= '0;
			color_q      <= rd_data_s1;
			last_q       <= (rd_idx_q == hdr_cnt_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign window_x   = window_x_q;
	assign window_y   = window_y_q;
	assign span_len   = span_len_q;
	assign color      = color_q;
	assign last       = last_q;

	`include "color_key_span_blitter_assert.svh"

	`CKB_ASSERT_NOW(a_busy_span_closed, state_q != S_IDLE, !span_open_q, "span open while emitting")
	`CKB_ASSERT_NOW(a_hdr_nonempty, state_q == S_HDR, hdr_cnt_q != '0, "closing span is empty")
	`CKB_ASSERT_NOW(a_rd_in_range, rd_valid_s1, (rd_idx_q != '0) && (rd_idx_q <= hdr_cnt_q), "read index out of span")
	`CKB_ASSERT_NEXT(a_hdr_to_pix, state_q == S_HDR && out_free, state_q == S_PIX && out_valid_q && kind_q == KIND_HEADER, "header not followed by pixel phase")

endmodule

`default_nettype wire
